/* sv/deq_pkg.sv */
// shared types and constants for the double-ended queue
package deq_pkg;

  // field widths of the stream items
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned MIDX_W = 4;
  localparam int unsigned CNT_W  = 5;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ       = 3'd4,
    CMD_WRITE      = 3'd5,
    CMD_FIND       = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take the input item and execute it
    logic load_read;  // store read data is ready, load the result
    logic find_step;  // compare one entry of a find walk
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // result register empty or being taken
    logic go_read;    // current item needs a store read
    logic go_find;    // current item starts a find walk
    logic find_done;  // find walk ends in this cycle
  } dp_stat_t;

endpackage

/* sv/deq_ctrl.sv */
// command sequencer of the double-ended queue
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  deq_pkg::dp_stat_t stat,
  output deq_pkg::ctl_cmd_t ctl
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FIND
  } state_t;

  state_t state_r;

  always_comb begin
    in_tready     = (state_r == S_IDLE) && stat.out_free;
    ctl.accept    = in_tvalid && in_tready;
    ctl.load_read = (state_r == S_READ);
    ctl.find_step = (state_r == S_FIND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctl.accept && stat.go_read) begin
            state_r <= S_READ;
          end else if (ctl.accept && stat.go_find) begin
            state_r <= S_FIND;
          end
        end
        S_READ: begin
          state_r <= S_IDLE;
        end
        S_FIND: begin
          if (stat.find_done) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/deq_dp.sv */
// datapath of the double-ended queue: circular store, pointers, result register
module deq_dp #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  deq_pkg::ctl_cmd_t           ctl,
  output deq_pkg::dp_stat_t           stat,
  input  logic [deq_pkg::CMD_W-1:0]   in_command,
  input  logic [deq_pkg::POS_W-1:0]   in_position,
  input  logic [deq_pkg::VAL_W-1:0]   in_data_value,
  input  logic                        out_tready,
  output logic                        out_tvalid,
  output logic [deq_pkg::STAT_W-1:0]  out_status,
  output logic [deq_pkg::VAL_W-1:0]   out_result_value,
  output logic [deq_pkg::MIDX_W-1:0]  out_match_index,
  output logic [deq_pkg::CNT_W-1:0]   out_entry_count
);
  import deq_pkg::*;

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PW-1:0]         front_r, front_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [PW-1:0]         idx_r, idx_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] rd_data_r;

  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [VAL_W-1:0]      out_value_r;
  logic [MIDX_W-1:0]     out_midx_r;
  logic [CNT_W-1:0]      out_count_r;

  logic                  wr_en, rd_en;
  logic [PW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] in_val;

  logic                  ld;
  status_t               ld_status;
  logic [DATA_WIDTH-1:0] ld_value;
  logic [PW-1:0]         ld_midx;

  logic                  is_full, is_empty, pos_ok, find_hit, find_last;
  logic [PW-1:0]         pos_idx;
  cmd_t                  cmd;

  // physical slot of a logical index, base + idx below twice the depth
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                            input logic [PW-1:0] idx);
    logic [PW:0] sum;
    begin
      sum = {1'b0, base} + {1'b0, idx};
      if (sum >= (PW + 1)'(DEPTH)) begin
        sum = sum - (PW + 1)'(DEPTH);
      end
      return sum[PW-1:0];
    end
  endfunction

  always_comb begin
    cmd       = cmd_t'(in_command);
    in_val    = DATA_WIDTH'(in_data_value);
    pos_idx   = PW'(in_position);
    is_full   = (count_r == CW'(DEPTH));
    is_empty  = (count_r == '0);
    pos_ok    = (CMPW'(in_position) < CMPW'(count_r));
    find_hit  = (rd_data_r == val_r);
    find_last = ((CW'(idx_r) + CW'(1)) == count_r);

    stat.out_free  = !out_valid_r || out_tready;
    stat.go_read   = (((cmd == CMD_POP_FRONT) || (cmd == CMD_POP_BACK)) && !is_empty)
                     || ((cmd == CMD_READ) && pos_ok);
    stat.go_find   = (cmd == CMD_FIND) && !is_empty;
    stat.find_done = find_hit || find_last;
  end

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    wr_data   = in_val;
    rd_en     = 1'b0;
    rd_addr   = front_r;
    ld        = 1'b0;
    ld_status = ST_OK;
    ld_value  = '0;
    ld_midx   = '0;

    if (ctl.accept) begin
      val_nxt = in_val;
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          ld = 1'b1;
          if (is_full) begin
            ld_status = ST_FULL;
          end else begin
            front_nxt = (front_r == '0) ? PW'(DEPTH - 1) : front_r - PW'(1);
            wr_en     = 1'b1;
            wr_addr   = front_nxt;
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_PUSH_BACK: begin
          ld = 1'b1;
          if (is_full) begin
            ld_status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = slot_of(front_r, PW'(count_r));
            count_nxt = count_r + CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (is_empty) begin
            ld        = 1'b1;
            ld_status = ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = front_r;
            front_nxt = (front_r == PW'(DEPTH - 1)) ? '0 : front_r + PW'(1);
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_POP_BACK: begin
          if (is_empty) begin
            ld        = 1'b1;
            ld_status = ST_EMPTY;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = slot_of(front_r, PW'(count_r - CW'(1)));
            count_nxt = count_r - CW'(1);
          end
        end
        CMD_READ: begin
          if (!pos_ok) begin
            ld        = 1'b1;
            ld_status = ST_RANGE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = slot_of(front_r, pos_idx);
          end
        end
        CMD_WRITE: begin
          ld = 1'b1;
          if (!pos_ok) begin
            ld_status = ST_RANGE;
          end else begin
            wr_en   = 1'b1;
            wr_addr = slot_of(front_r, pos_idx);
          end
        end
        CMD_FIND: begin
          if (is_empty) begin
            ld        = 1'b1;
            ld_status = ST_NOT_FOUND;
          end else begin
            rd_en   = 1'b1;
            rd_addr = front_r;
            idx_nxt = '0;
          end
        end
        default: begin
          ld = 1'b1;
        end
      endcase
    end else if (ctl.load_read) begin
      ld       = 1'b1;
      ld_value = rd_data_r;
    end else if (ctl.find_step) begin
      if (find_hit) begin
        ld       = 1'b1;
        ld_value = rd_data_r;
        ld_midx  = idx_r;
      end else if (find_last) begin
        ld        = 1'b1;
        ld_status = ST_NOT_FOUND;
      end else begin
        idx_nxt = idx_r + PW'(1);
        rd_en   = 1'b1;
        rd_addr = slot_of(front_r, idx_nxt);
      end
    end
  end

  // entry store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    if (ld) begin
      out_status_r <= ld_status;
      out_value_r  <= VAL_W'(ld_value);
      out_midx_r   <= MIDX_W'(ld_midx);
      out_count_r  <= CNT_W'(count_nxt);
    end
  end

  assign out_tvalid       = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_match_index  = out_midx_r;
  assign out_entry_count  = out_count_r;

endmodule

/* sv/double_ended_queue.sv */
// top level of the double-ended queue: stream ports, controller and datapath
// timing: push, write, error and unused codes load the result register on accept;
//   pop and read load it from the registered read of the entry store in S_READ; find
//   steps through S_FIND from the front until a match or the last held entry
// throughput: one item at a time, taken once the output register is empty or its item
//   goes out in the same cycle; reset clears front pointer, count and output valid flag
module double_ended_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // slave side
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] command, [6:3] position, [38:7] data_value, [39] zero
  input  logic [deq_pkg::IN_TDATA_W-1:0]      in_tdata,
  // master side
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] status, [34:3] result_value, [38:35] match_index,
  // [43:39] entry_count, [47:44] zero
  output logic [deq_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import deq_pkg::*;

  ctl_cmd_t          ctl;
  dp_stat_t          stat;

  logic [STAT_W-1:0] out_status;
  logic [VAL_W-1:0]  out_result_value;
  logic [MIDX_W-1:0] out_match_index;
  logic [CNT_W-1:0]  out_entry_count;

  // sequencer: idle, waiting on store read data, or walking a find
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // store, front pointer, count and the result register
  deq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .stat             (stat),
    .in_command       (in_tdata[2:0]),
    .in_position      (in_tdata[6:3]),
    .in_data_value    (in_tdata[38:7]),
    .out_tready       (out_tready),
    .out_tvalid       (out_tvalid),
    .out_status       (out_status),
    .out_result_value (out_result_value),
    .out_match_index  (out_match_index),
    .out_entry_count  (out_entry_count)
  );

  // pad bits of the result item stay zero
  assign out_tdata = {4'b0000, out_entry_count, out_match_index,
                      out_result_value, out_status};

endmodule
